/* design/tsm_pkg.sv */
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants for the tamper suspicion monitor: command and
// status codes, register indexes and the register reset values.
// ----------------------------------------------------------------------------
package tsm_pkg;

   localparam int unsigned COUNT_WIDTH_DEFAULT = 16;

   localparam int unsigned CMD_WIDTH    = 4;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned CSR_IDX_W    = 3;
   localparam int unsigned CSR_DATA_W   = 16;
   localparam int unsigned LIMIT_W      = 16;
   localparam int unsigned WEIGHT_W     = 8;
   localparam int unsigned SEC_W        = 32;
   localparam int unsigned MS_W         = 10;
   localparam int unsigned SEV_W        = 8;

   localparam logic [SEC_W-1:0] MS_PER_S     = 32'd1000;
   localparam logic [SEV_W-1:0] SEV_WARNING  = 8'd1;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_BEAT      = 4'd0,
      CMD_ZEROIZE   = 4'd1,
      CMD_READ      = 4'd2,
      CMD_VOLTAGE   = 4'd3,
      CMD_TEMP      = 4'd4,
      CMD_BREACH    = 4'd5,
      CMD_RESET     = 4'd6,
      CMD_I2C       = 4'd7
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_SUCCESS    = 2'd0,
      ST_BAD_PARAMS = 2'd1,
      ST_DENIED     = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SILENCE_LIMIT = 3'd0,
      CSR_JITTER_LIMIT  = 3'd1,
      CSR_EVENT_TRIP    = 3'd2,
      CSR_BEAT_TRIP     = 3'd3,
      CSR_VOLTAGE_WT    = 3'd4,
      CSR_TEMP_WT       = 3'd5,
      CSR_SILENCE_WT    = 3'd6,
      CSR_JITTER_WT     = 3'd7
   } csr_idx_type;

   localparam logic [LIMIT_W-1:0]  RST_SILENCE_LIMIT = 16'd2000;
   localparam logic [LIMIT_W-1:0]  RST_JITTER_LIMIT  = 16'd3000;
   localparam logic [LIMIT_W-1:0]  RST_EVENT_TRIP    = 16'd50;
   localparam logic [LIMIT_W-1:0]  RST_BEAT_TRIP     = 16'd100;
   localparam logic [WEIGHT_W-1:0] RST_VOLTAGE_WT    = 8'd30;
   localparam logic [WEIGHT_W-1:0] RST_TEMP_WT       = 8'd25;
   localparam logic [WEIGHT_W-1:0] RST_SILENCE_WT    = 8'd10;
   localparam logic [WEIGHT_W-1:0] RST_JITTER_WT     = 8'd5;

endpackage

/* design/tamper_suspicion_monitor_core.sv */
// ----------------------------------------------------------------------------
// tamper_suspicion_monitor_core
// A request is held in the input register, then its response in the result
// register, from which it can be taken. Throughput: one transaction per cycle
// unless rsp_stall holds a result; the score, counter, armed flag and
// heartbeat time are all updated in the single compute stage, so a command
// sees the result of the one before it without a bubble.
// Reset (synchronous, active high) clears score, counter and heartbeat time,
// arms the keys and loads the default limits and weights.
// ----------------------------------------------------------------------------
module tamper_suspicion_monitor_core
   import tsm_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_WIDTH-1:0]      req_cmd,
   input  logic [SEC_W-1:0]          req_now_seconds,
   input  logic [MS_W-1:0]           req_now_millis,
   input  logic                      req_params_ok,
   input  logic [SEV_W-1:0]          req_severity,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STATUS_WIDTH-1:0]   rsp_status,
   output logic [COUNT_WIDTH-1:0]    rsp_event_count,
   output logic [COUNT_WIDTH-1:0]    rsp_score,
   output logic                      rsp_keys_armed
);

   localparam int unsigned SUM_W = COUNT_WIDTH + 1;
   localparam int unsigned CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
   localparam logic [COUNT_WIDTH-1:0] SAT_MAX = {COUNT_WIDTH{1'b1}};

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [WEIGHT_W-1:0] b);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, a} + SUM_W'(b);
      return sum[COUNT_WIDTH] ? SAT_MAX : sum[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic above(input logic [COUNT_WIDTH-1:0] value,
                                  input logic [LIMIT_W-1:0] limit);
      return CMP_W'(value) > CMP_W'(limit);
   endfunction

   // configuration registers
   logic [LIMIT_W-1:0]  silence_limit_ff, jitter_limit_ff, event_trip_ff, beat_trip_ff;
   logic [WEIGHT_W-1:0] voltage_wt_ff, temp_wt_ff, silence_wt_ff, jitter_wt_ff;

   // monitor state
   logic [SEC_W-1:0]       last_sec_ff, last_sec_in;
   logic [MS_W-1:0]        last_ms_ff, last_ms_in;
   logic [COUNT_WIDTH-1:0] susp_ff, susp_in;
   logic [COUNT_WIDTH-1:0] jrnl_ff, jrnl_in;
   logic                   armed_ff, armed_in;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [CMD_WIDTH-1:0] cmd_ff;
   logic [SEC_W-1:0]     now_sec_ff;
   logic [MS_W-1:0]      now_ms_ff;
   logic                 params_ok_ff;
   logic [SEV_W-1:0]     severity_ff;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic [COUNT_WIDTH-1:0]  count_out_ff, score_out_ff;
   logic                    armed_out_ff;

   logic            out_ready, req_take, work_go, store_beat;
   logic [SEC_W-1:0] gap;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign work_go   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !out_ready);
   assign rsp_valid_in = work_go || (rsp_valid_ff && rsp_stall);

   // gap in ms since the last heartbeat, wrapping modulo 2^32
   assign gap = (now_sec_ff - last_sec_ff) * MS_PER_S
              + (SEC_W'(now_ms_ff) - SEC_W'(last_ms_ff));

   always_comb begin
      logic                   seen;
      logic [COUNT_WIDTH-1:0] s;
      logic [COUNT_WIDTH-1:0] j;
      logic                   a;
      status_type             st;
      seen = (last_sec_ff != '0);
      s    = susp_ff;
      j    = jrnl_ff;
      a    = armed_ff;
      st   = ST_SUCCESS;
      store_beat = 1'b0;

      if (seen && (gap > SEC_W'(silence_limit_ff))) begin
         s = sat_add(s, silence_wt_ff);
         j = sat_add(j, WEIGHT_W'(1));
         if (above(s, event_trip_ff) && a) begin
            a = 1'b0;
            j = sat_add(j, WEIGHT_W'(1));
         end
      end

      unique case (cmd_ff) inside
         CMD_BEAT: begin
            if (seen) begin
               if (gap > SEC_W'(jitter_limit_ff)) begin
                  s = sat_add(s, jitter_wt_ff);
                  j = sat_add(j, WEIGHT_W'(1));
               end else if (s != '0) begin
                  s = s - COUNT_WIDTH'(1);
               end
               if (above(s, beat_trip_ff) && a) begin
                  a = 1'b0;
                  j = sat_add(j, WEIGHT_W'(1));
               end
            end
            if (!a) st = ST_DENIED;
            else    store_beat = 1'b1;
         end
         CMD_ZEROIZE: begin
            if (a) begin
               a = 1'b0;
               j = sat_add(j, WEIGHT_W'(1));
            end
         end
         CMD_READ: begin
            if (!params_ok_ff) st = ST_BAD_PARAMS;
         end
         CMD_VOLTAGE, CMD_TEMP: begin
            j = sat_add(j, WEIGHT_W'(1));
            s = sat_add(s, (cmd_ff == CMD_VOLTAGE) ? voltage_wt_ff : temp_wt_ff);
            if (above(s, event_trip_ff) && a) begin
               a = 1'b0;
               j = sat_add(j, WEIGHT_W'(1));
            end
         end
         CMD_BREACH: begin
            j = sat_add(j, WEIGHT_W'(1));
            if (a) begin
               a = 1'b0;
               j = sat_add(j, WEIGHT_W'(1));
            end
         end
         CMD_RESET: begin
            j = '0;
            s = '0;
            a = 1'b1;
         end
         CMD_I2C: begin
            if (!params_ok_ff) begin
               st = ST_BAD_PARAMS;
            end else begin
               j = sat_add(j, WEIGHT_W'(1));
               if (severity_ff == SEV_WARNING) begin
                  s = sat_add(s, voltage_wt_ff);
                  if (above(s, event_trip_ff) && a) begin
                     a = 1'b0;
                     j = sat_add(j, WEIGHT_W'(1));
                  end
               end else if (a) begin
                  a = 1'b0;
                  j = sat_add(j, WEIGHT_W'(1));
               end
            end
         end
         default: st = ST_BAD_PARAMS;
      endcase

      susp_in     = s;
      jrnl_in     = j;
      armed_in    = a;
      status_in   = st;
      last_sec_in = store_beat ? now_sec_ff : last_sec_ff;
      last_ms_in  = store_beat ? now_ms_ff  : last_ms_ff;
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_sec_ff  <= '0;
         last_ms_ff   <= '0;
         susp_ff      <= '0;
         jrnl_ff      <= '0;
         armed_ff     <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (work_go) begin
            last_sec_ff <= last_sec_in;
            last_ms_ff  <= last_ms_in;
            susp_ff     <= susp_in;
            jrnl_ff     <= jrnl_in;
            armed_ff    <= armed_in;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         silence_limit_ff <= RST_SILENCE_LIMIT;
         jitter_limit_ff  <= RST_JITTER_LIMIT;
         event_trip_ff    <= RST_EVENT_TRIP;
         beat_trip_ff     <= RST_BEAT_TRIP;
         voltage_wt_ff    <= RST_VOLTAGE_WT;
         temp_wt_ff       <= RST_TEMP_WT;
         silence_wt_ff    <= RST_SILENCE_WT;
         jitter_wt_ff     <= RST_JITTER_WT;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SILENCE_LIMIT: silence_limit_ff <= csr_wdata;
            CSR_JITTER_LIMIT:  jitter_limit_ff  <= csr_wdata;
            CSR_EVENT_TRIP:    event_trip_ff    <= csr_wdata;
            CSR_BEAT_TRIP:     beat_trip_ff     <= csr_wdata;
            CSR_VOLTAGE_WT:    voltage_wt_ff    <= csr_wdata[WEIGHT_W-1:0];
            CSR_TEMP_WT:       temp_wt_ff       <= csr_wdata[WEIGHT_W-1:0];
            CSR_SILENCE_WT:    silence_wt_ff    <= csr_wdata[WEIGHT_W-1:0];
            CSR_JITTER_WT:     jitter_wt_ff     <= csr_wdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // payload registers: load input on accept, result when the stage fires
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff       <= req_cmd;
         now_sec_ff   <= req_now_seconds;
         now_ms_ff    <= req_now_millis;
         params_ok_ff <= req_params_ok;
         severity_ff  <= req_severity;
      end
      if (work_go) begin
         status_ff    <= status_in;
         count_out_ff <= jrnl_in;
         score_out_ff <= susp_in;
         armed_out_ff <= armed_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_event_count = count_out_ff;
   assign rsp_score       = score_out_ff;
   assign rsp_keys_armed  = armed_out_ff;

   // a reset command always leaves a clean, armed response behind it
   a_reset_cmd_clears: assert property (@(posedge clock) disable iff (reset)
      (work_go && (cmd_ff == CMD_RESET)) |=>
         (rsp_valid && rsp_keys_armed && (rsp_score == '0) && (rsp_event_count == '0)))
      else $error("reset command did not clear score, counter and armed flag");

   // keys can only be re-armed by a reset command
   a_rearm_only_by_reset: assert property (@(posedge clock) disable iff (reset)
      ($rose(armed_ff) && !$past(reset)) |->
         $past(work_go && (cmd_ff == CMD_RESET)))
      else $error("keys re-armed without a reset command");

   // journal counter only moves when a command is processed
   a_journal_only_on_work: assert property (@(posedge clock) disable iff (reset)
      !work_go |=> $stable(jrnl_ff))
      else $error("journal counter changed with no command in flight");

   // zeroize command always leaves the keys disarmed
   a_zeroize_disarms: assert property (@(posedge clock) disable iff (reset)
      (work_go && (cmd_ff == CMD_ZEROIZE)) |=> (rsp_valid && !rsp_keys_armed))
      else $error("zeroize command left keys armed");

endmodule
